[rtl/strict_decimal_text_to_ticks_assert.svh]
// Assertion macros for the decimal text to ticks block
`ifndef STRICT_DECIMAL_TEXT_TO_TICKS_ASSERT_SVH
`define STRICT_DECIMAL_TEXT_TO_TICKS_ASSERT_SVH

`ifndef SYNTHESIS
`define SDTT_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdtt check failed");
`define SDTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdtt check failed");
`else
`define SDTT_ASSERT(lbl, clk, rst_n, ante, cons)
`define SDTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/sdtt_pkg.sv]
`default_nettype none

package sdtt_pkg;

    localparam int VAL_W = 63;
    localparam int FRAC_W = 60;
    localparam int FDC_W = 5;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_MALFORMED = 3'd1;
    localparam t_status ST_OFF_TICK  = 3'd2;
    localparam t_status ST_PRICE_RNG = 3'd3;
    localparam t_status ST_NONPOS    = 3'd4;
    localparam t_status ST_OFF_LOT   = 3'd5;
    localparam t_status ST_QTY_RNG   = 3'd6;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_PRICE_SCALE = 2'd0;
    localparam t_reg_idx REG_QTY_SCALE   = 2'd1;
    localparam t_reg_idx REG_TICK_SIZE   = 2'd2;
    localparam t_reg_idx REG_LOT_SIZE    = 2'd3;

    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend;
        logic [VAL_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quotient;
        logic [VAL_W-1:0] remainder;
    } t_div_rsp;

    function automatic logic [VAL_W+3:0] mul10(input logic [VAL_W-1:0] x,
                                              input logic [3:0] d);
        logic [VAL_W+3:0] xw;
        xw = {4'b0, x};
        return (xw << 3) + (xw << 1) + {{VAL_W{1'b0}}, d};
    endfunction

endpackage

`default_nettype wire

[rtl/sdtt_div.sv]
`default_nettype none

module sdtt_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sdtt_pkg::t_div_req i_req,
    output sdtt_pkg::t_div_rsp     o_rsp
);

    localparam int W = sdtt_pkg::VAL_W;

    logic         r_busy;
    logic         r_done;
    logic [5:0]   r_cnt;
    logic [W-1:0] r_q;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_div;

    logic [W:0]   w_shift;
    logic [W+1:0] w_trial;
    logic         w_fit;

    assign w_shift = {r_rem, r_q[W-1]};
    assign w_trial = {1'b0, w_shift} - {2'b0, r_div};
    assign w_fit   = !w_trial[W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_trial[W-1:0] : w_shift[W-1:0];
            r_q   <= {r_q[W-2:0], w_fit};
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_q;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

[rtl/strict_decimal_text_to_ticks.sv]
// Channel     Dir  Handshake                     Payload
// s_axis      in   s_axis_tvalid/s_axis_tready   char in tdata, kind in tuser, tlast
// m_axis      out  m_axis_tvalid/m_axis_tready   count and status in tdata, kind in tuser
// apb         in   psel/penable/pwrite/pready    4 registers at byte address 8*i
//
// A character that is not last passes through S_CHAR and back to S_IDLE.
// A last character then runs through S_PAD, S_SCALE and S_DIV to S_DONE (an error
// skips ahead to S_DONE), using the shared times-ten unit and the bit-serial 63-bit divider.
// s_axis_tready is low while an item is at work; a waiting result stalls only
// the next result, not the next characters. Synchronous reset, no clearing pass.
`default_nettype none

`include "strict_decimal_text_to_ticks_assert.svh"

module strict_decimal_text_to_ticks #(
    parameter int PRICE_BITS = 32,
    parameter int QTY_BITS   = 32,
    parameter int SCALE_MAX  = 18
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_char
    input  wire logic        s_axis_tuser,   // [0] is_quantity
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [30:0] count, [33:31] status, [39:34] zero
    output logic             m_axis_tuser,   // [0] is_quantity
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    localparam int W = sdtt_pkg::VAL_W;
    localparam int FW = sdtt_pkg::FRAC_W;
    localparam int CW = sdtt_pkg::FDC_W;
    localparam logic [CW-1:0] SCALE_LIM = CW'(SCALE_MAX);
    localparam logic [W-1:0] P_LIMIT = (W'(1) << (PRICE_BITS - 1)) - W'(1);
    localparam logic [W-1:0] Q_LIMIT = (W'(1) << (QTY_BITS - 1)) - W'(1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHAR  = 6'b000010,
        S_PAD   = 6'b000100,
        S_SCALE = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0] r_pscale, r_qscale;
    logic [W-1:0]  r_tick, r_lot;

    logic [7:0]    r_ch, n_ch;
    logic          r_qty, n_qty;
    logic          r_last, n_last;
    logic [W-1:0]  r_ip, n_ip;
    logic [FW-1:0] r_frac, n_frac;
    logic [CW-1:0] r_fdc, n_fdc;
    logic [CW-1:0] r_k, n_k;
    logic          r_any, n_any;
    logic          r_in_frac, n_in_frac;
    logic          r_first, n_first;
    logic          r_err, n_err;
    logic [30:0]   r_res_count, n_res_count;
    sdtt_pkg::t_status r_res_status, n_res_status;

    logic          r_out_valid, n_out_valid;
    logic [30:0]   r_out_count;
    sdtt_pkg::t_status r_out_status;
    logic          r_out_qty;
    logic          w_out_load;

    logic [CW-1:0] w_scale;
    logic [3:0]    w_digit;
    logic [W-1:0]  w_mul_op;
    logic [3:0]    w_mul_d;
    logic [W+3:0]  w_mul;
    logic [W:0]    w_sum;
    logic [W-1:0]  w_unit;
    logic [W-1:0]  w_limit;
    logic          w_accept;
    logic          w_cfg_wr;

    sdtt_pkg::t_div_req w_div_req;
    sdtt_pkg::t_div_rsp w_div_rsp;

    sdtt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign pready        = 1'b1;
    assign w_cfg_wr      = psel && penable && pwrite && pready;

    always_comb begin
        case (sdtt_pkg::t_reg_idx'(paddr[4:3]))
            sdtt_pkg::REG_PRICE_SCALE: prdata = {59'b0, r_pscale};
            sdtt_pkg::REG_QTY_SCALE:   prdata = {59'b0, r_qscale};
            sdtt_pkg::REG_TICK_SIZE:   prdata = {1'b0, r_tick};
            sdtt_pkg::REG_LOT_SIZE:    prdata = {1'b0, r_lot};
            default:                   prdata = '0;
        endcase
    end

    assign w_scale = r_qty ? r_qscale : r_pscale;
    assign w_digit = 4'(r_ch - sdtt_pkg::CH_0);
    assign w_unit  = r_qty ? r_lot : r_tick;
    assign w_limit = r_qty ? Q_LIMIT : P_LIMIT;
    assign w_sum   = {1'b0, r_ip} + {{(W + 1 - FW){1'b0}}, r_frac};

    always_comb begin
        case (r_state)
            S_CHAR:  w_mul_op = r_in_frac ? W'(r_frac) : r_ip;
            S_PAD:   w_mul_op = W'(r_frac);
            default: w_mul_op = r_ip;
        endcase
        w_mul_d = (r_state == S_CHAR) ? w_digit : 4'd0;
        w_mul   = sdtt_pkg::mul10(w_mul_op, w_mul_d);
    end

    always_comb begin
        n_state      = r_state;
        n_ch         = r_ch;
        n_qty        = r_qty;
        n_last       = r_last;
        n_ip         = r_ip;
        n_frac       = r_frac;
        n_fdc        = r_fdc;
        n_k          = r_k;
        n_any        = r_any;
        n_in_frac    = r_in_frac;
        n_first      = r_first;
        n_err        = r_err;
        n_res_count  = r_res_count;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !m_axis_tready;
        w_out_load   = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_sum[W-1:0];
        w_div_req.divisor  = w_unit;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_ch    = s_axis_tdata;
                    n_qty   = s_axis_tuser;
                    n_last  = s_axis_tlast;
                    n_state = S_CHAR;
                end
            end
            S_CHAR: begin
                n_first = 1'b0;
                if (!r_err && !(r_first && r_ch == sdtt_pkg::CH_PLUS)) begin
                    if (r_ch == sdtt_pkg::CH_DOT) begin
                        if (r_in_frac) begin
                            n_err = 1'b1;
                        end else begin
                            n_in_frac = 1'b1;
                        end
                    end else if (r_ch < sdtt_pkg::CH_0 || r_ch > sdtt_pkg::CH_9) begin
                        n_err = 1'b1;
                    end else if (!r_in_frac) begin
                        if (w_mul[W+3:W] != 4'd0) begin
                            n_err = 1'b1;
                        end else begin
                            n_ip  = w_mul[W-1:0];
                            n_any = 1'b1;
                        end
                    end else if (w_scale > SCALE_LIM || r_fdc >= w_scale) begin
                        n_err = 1'b1;
                    end else begin
                        n_frac = w_mul[FW-1:0];
                        n_fdc  = r_fdc + CW'(1);
                        n_any  = 1'b1;
                    end
                end
                n_res_count = '0;
                n_state     = r_last ? S_PAD : S_IDLE;
            end
            S_PAD: begin
                if (r_err || !r_any || w_scale > SCALE_LIM || r_fdc > w_scale) begin
                    n_res_status = sdtt_pkg::ST_MALFORMED;
                    n_state      = S_DONE;
                end else if (r_fdc == w_scale) begin
                    n_k     = '0;
                    n_state = S_SCALE;
                end else begin
                    n_frac = w_mul[FW-1:0];
                    n_fdc  = r_fdc + CW'(1);
                end
            end
            S_SCALE: begin
                if (r_k == w_scale) begin
                    if (w_sum[W]) begin
                        n_res_status = sdtt_pkg::ST_MALFORMED;
                        n_state      = S_DONE;
                    end else if (w_sum == '0) begin
                        n_res_status = r_qty ? sdtt_pkg::ST_NONPOS : sdtt_pkg::ST_MALFORMED;
                        n_state      = S_DONE;
                    end else if (w_unit == '0) begin
                        n_res_status = r_qty ? sdtt_pkg::ST_OFF_LOT : sdtt_pkg::ST_OFF_TICK;
                        n_state      = S_DONE;
                    end else begin
                        w_div_req.start = 1'b1;
                        n_state         = S_DIV;
                    end
                end else if (w_mul[W+3:W] != 4'd0) begin
                    n_res_status = sdtt_pkg::ST_MALFORMED;
                    n_state      = S_DONE;
                end else begin
                    n_ip = w_mul[W-1:0];
                    n_k  = r_k + CW'(1);
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.remainder != '0) begin
                        n_res_status = r_qty ? sdtt_pkg::ST_OFF_LOT : sdtt_pkg::ST_OFF_TICK;
                    end else if (w_div_rsp.quotient > w_limit) begin
                        n_res_status = r_qty ? sdtt_pkg::ST_QTY_RNG : sdtt_pkg::ST_PRICE_RNG;
                    end else begin
                        n_res_status = sdtt_pkg::ST_OK;
                        n_res_count  = w_div_rsp.quotient[30:0];
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_ip        = '0;
                    n_frac      = '0;
                    n_fdc       = '0;
                    n_any       = 1'b0;
                    n_in_frac   = 1'b0;
                    n_first     = 1'b1;
                    n_err       = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pscale    <= CW'(2);
            r_qscale    <= '0;
            r_tick      <= W'(1);
            r_lot       <= W'(1);
            r_ip        <= '0;
            r_frac      <= '0;
            r_fdc       <= '0;
            r_any       <= 1'b0;
            r_in_frac   <= 1'b0;
            r_first     <= 1'b1;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ip        <= n_ip;
            r_frac      <= n_frac;
            r_fdc       <= n_fdc;
            r_any       <= n_any;
            r_in_frac   <= n_in_frac;
            r_first     <= n_first;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr) begin
                case (sdtt_pkg::t_reg_idx'(paddr[4:3]))
                    sdtt_pkg::REG_PRICE_SCALE: r_pscale <= pwdata[CW-1:0];
                    sdtt_pkg::REG_QTY_SCALE:   r_qscale <= pwdata[CW-1:0];
                    sdtt_pkg::REG_TICK_SIZE:   r_tick   <= pwdata[W-1:0];
                    sdtt_pkg::REG_LOT_SIZE:    r_lot    <= pwdata[W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch         <= n_ch;
        r_qty        <= n_qty;
        r_last       <= n_last;
        r_k          <= n_k;
        r_res_count  <= n_res_count;
        r_res_status <= n_res_status;
        if (w_out_load) begin
            r_out_count  <= r_res_count;
            r_out_status <= r_res_status;
            r_out_qty    <= r_qty;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_status, r_out_count};
    assign m_axis_tuser  = r_out_qty;

    `SDTT_ASSERT(a_err_zero_count, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[33:31] != sdtt_pkg::ST_OK), m_axis_tdata[30:0] == 31'd0)
    `SDTT_ASSERT_NEXT(a_accept_to_char, i_clk, i_rst_n, w_accept, r_state == S_CHAR)
    `SDTT_ASSERT(a_fdc_bound, i_clk, i_rst_n, 1'b1, r_fdc <= SCALE_LIM)
    `SDTT_ASSERT(a_div_done_in_div, i_clk, i_rst_n, w_div_rsp.done, r_state == S_DIV)

endmodule

`default_nettype wire
